@@ rtl/tpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tpd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int TABLE_LEN    = 24;
    localparam int CSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SQRT_STEPS   = 32;
    localparam int CNT_W        = 5;
    localparam int DATA_W       = 16;
    localparam int ADDR_W       = 2;
    localparam int CX_W         = 36;
    localparam int CZ_W         = 32;
    localparam int E_W          = 17;
    localparam int D_W          = 18;
    localparam int U_W          = SUM_WIDTH + 18;

    localparam logic [ADDR_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [ADDR_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [ADDR_W-1:0] REG_GAIN_D = 2'd2;
    localparam logic [ADDR_W-1:0] REG_TARGET = 2'd3;

    localparam logic [14:0] DAC_CTRL    = 15'h7000;
    localparam logic [11:0] CODE_HIGH   = 12'd4095;
    localparam logic [11:0] CODE_LOW    = 12'd124;
    localparam logic [11:0] DEG_MUL     = 12'd2250;
    localparam logic [43:0] DEG_BIAS    = 44'd157 << 19;
    localparam logic [24:0] DEG_RECIP   = 25'd27356480;
    localparam logic [13:0] DAC_MUL     = 14'd13650;
    localparam logic [16:0] DIV11_RECIP = 17'd95326;
    localparam logic signed [U_W-1:0] V_HIGH_MIN = U_W'(216269);
    localparam logic signed [U_W-1:0] V_LOW_MAX  = U_W'(6553);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQZ, ST_SQRT, ST_CINIT, ST_CSTEP, ST_DEGMUL, ST_DEGDIV,
        ST_ERR, ST_MP, ST_MI, ST_MD, ST_SCALE, ST_CODE, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_SQX, CMD_SQZ, CMD_SQRT, CMD_CINIT, CMD_CSTEP,
        CMD_DEGMUL, CMD_DEGDIV, CMD_ERR, CMD_MP, CMD_MI, CMD_MD, CMD_SCALE,
        CMD_CODE, CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic in_y_zero;
        logic out_free;
    } status_t;

    // atan(2^-i), radians Q2.30, truncated
    function automatic logic [CZ_W-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [CZ_W-1:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tpd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tpd_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire tpd_pkg::status_t status,
    output tpd_pkg::cmd_t        cmd
);

    tpd_pkg::state_t state_reg, state_next;
    logic [tpd_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic sqrt_last, cordic_last;
    assign sqrt_last   = (cnt_reg == tpd_pkg::CNT_W'(tpd_pkg::SQRT_STEPS - 1));
    assign cordic_last = (cnt_reg == tpd_pkg::CNT_W'(tpd_pkg::CSTEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            tpd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (status.in_tick)
                        state_next = tpd_pkg::ST_ERR;
                    else if (!status.in_y_zero)
                        state_next = tpd_pkg::ST_SQX;
                end
            end
            tpd_pkg::ST_SQX:    state_next = tpd_pkg::ST_SQZ;
            tpd_pkg::ST_SQZ:    state_next = tpd_pkg::ST_SQRT;
            tpd_pkg::ST_SQRT: begin
                if (sqrt_last)
                    state_next = tpd_pkg::ST_CINIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            tpd_pkg::ST_CINIT:  state_next = tpd_pkg::ST_CSTEP;
            tpd_pkg::ST_CSTEP: begin
                if (cordic_last)
                    state_next = tpd_pkg::ST_DEGMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            tpd_pkg::ST_DEGMUL: state_next = tpd_pkg::ST_DEGDIV;
            tpd_pkg::ST_DEGDIV: state_next = tpd_pkg::ST_IDLE;
            tpd_pkg::ST_ERR:    state_next = tpd_pkg::ST_MP;
            tpd_pkg::ST_MP:     state_next = tpd_pkg::ST_MI;
            tpd_pkg::ST_MI:     state_next = tpd_pkg::ST_MD;
            tpd_pkg::ST_MD:     state_next = tpd_pkg::ST_SCALE;
            tpd_pkg::ST_SCALE:  state_next = tpd_pkg::ST_CODE;
            tpd_pkg::ST_CODE:   state_next = tpd_pkg::ST_OUT;
            tpd_pkg::ST_OUT: begin
                if (status.out_free)
                    state_next = tpd_pkg::ST_IDLE;
            end
            default:            state_next = tpd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.op  = tpd_pkg::CMD_NONE;
        cmd.cnt = cnt_reg;
        case (state_reg)
            tpd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid)
                    cmd.op = tpd_pkg::CMD_LOAD;
            end
            tpd_pkg::ST_SQX:    cmd.op = tpd_pkg::CMD_SQX;
            tpd_pkg::ST_SQZ:    cmd.op = tpd_pkg::CMD_SQZ;
            tpd_pkg::ST_SQRT:   cmd.op = tpd_pkg::CMD_SQRT;
            tpd_pkg::ST_CINIT:  cmd.op = tpd_pkg::CMD_CINIT;
            tpd_pkg::ST_CSTEP:  cmd.op = tpd_pkg::CMD_CSTEP;
            tpd_pkg::ST_DEGMUL: cmd.op = tpd_pkg::CMD_DEGMUL;
            tpd_pkg::ST_DEGDIV: cmd.op = tpd_pkg::CMD_DEGDIV;
            tpd_pkg::ST_ERR:    cmd.op = tpd_pkg::CMD_ERR;
            tpd_pkg::ST_MP:     cmd.op = tpd_pkg::CMD_MP;
            tpd_pkg::ST_MI:     cmd.op = tpd_pkg::CMD_MI;
            tpd_pkg::ST_MD:     cmd.op = tpd_pkg::CMD_MD;
            tpd_pkg::ST_SCALE:  cmd.op = tpd_pkg::CMD_SCALE;
            tpd_pkg::ST_CODE:   cmd.op = tpd_pkg::CMD_CODE;
            tpd_pkg::ST_OUT: begin
                if (status.out_free)
                    cmd.op = tpd_pkg::CMD_OUT;
            end
            default:            cmd.op = tpd_pkg::CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tpd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tpd_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tpd_pkg::cmd_t                       cmd,
    output tpd_pkg::status_t                         status,
    input  wire logic                                s_op,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_x,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_y,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_z,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tpd_pkg::ADDR_W-1:0]          cfg_addr,
    input  wire logic [tpd_pkg::DATA_W-1:0]          cfg_wdata,
    input  wire logic                                m_ready,
    output logic                                     m_valid,
    output logic [14:0]                              m_dac_word,
    output logic signed [tpd_pkg::DATA_W-1:0]        m_tilt_now
);

    localparam int SW = tpd_pkg::SUM_WIDTH;
    localparam int XW = tpd_pkg::CX_W;
    localparam int ZW = tpd_pkg::CZ_W;
    localparam int UW = tpd_pkg::U_W;

    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg, target_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] tilt_reg;
    logic signed [tpd_pkg::E_W-1:0] last_err_reg, e_reg;
    logic signed [tpd_pkg::D_W-1:0] diff_reg;
    logic signed [SW-1:0] sum_reg;
    logic [31:0] sq_reg, nsh_reg, root_reg;
    logic [33:0] rem_reg;
    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [43:0] nrm_reg;
    logic zneg_reg;
    logic signed [UW-1:0] u_reg;
    logic hi_reg, lo_reg;
    logic [15:0] w_reg;
    logic [11:0] code_reg;
    logic m_valid_reg;
    logic [14:0] m_dac_word_reg;
    logic signed [15:0] m_tilt_reg;

    assign status.in_tick   = s_op;
    assign status.in_y_zero = (s_accel_y == '0);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_dac_word = m_dac_word_reg;
    assign m_tilt_now = m_tilt_reg;

    // squares
    logic signed [31:0] sqx, sqz;
    assign sqx = ax_reg * ax_reg;
    assign sqz = az_reg * az_reg;

    // one result bit per step of the square root
    logic [35:0] rem_w, trial;
    logic        take;
    assign rem_w = {rem_reg, nsh_reg[31:30]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign take  = (rem_w >= trial);

    // CORDIC vectoring step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    assign dx  = cy_reg >>> cmd.cnt;
    assign dy  = cx_reg >>> cmd.cnt;
    assign ang = $signed(tpd_pkg::atan_q30(cmd.cnt));

    // radians Q30 to degrees Q8.8, halves away from zero
    logic [ZW-1:0] zabs;
    logic [43:0]   deg_prod;
    logic [48:0]   q_prod;
    logic [15:0]   qq;
    assign zabs     = cz_reg[ZW-1] ? ZW'(-cz_reg) : ZW'(cz_reg);
    assign deg_prod = 44'(zabs[30:0]) * 44'(tpd_pkg::DEG_MUL);
    assign q_prod   = 49'(nrm_reg[43:20]) * 49'(tpd_pkg::DEG_RECIP);
    assign qq       = q_prod[47:32];

    // error, derivative, saturating sum
    logic signed [tpd_pkg::E_W-1:0] e_w;
    logic signed [tpd_pkg::D_W-1:0] diff_w;
    logic signed [SW:0]             s_w;
    logic signed [SW-1:0]           s_sat;
    assign e_w    = tpd_pkg::E_W'(target_reg) - tpd_pkg::E_W'(tilt_reg);
    assign diff_w = tpd_pkg::D_W'(e_w) - tpd_pkg::D_W'(last_err_reg);
    assign s_w    = (SW + 1)'(sum_reg) + (SW + 1)'(e_w);
    always_comb begin
        if (s_w[SW] != s_w[SW-1])
            s_sat = s_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            s_sat = s_w[SW-1:0];
    end

    // shared gain multiplier
    logic signed [15:0]    mul_a;
    logic signed [SW-1:0]  mul_b;
    logic signed [SW+15:0] mul_p;
    logic signed [UW-1:0]  mul_x;
    always_comb begin
        case (cmd.op)
            tpd_pkg::CMD_MI: begin
                mul_a = gain_i_reg;
                mul_b = sum_reg;
            end
            tpd_pkg::CMD_MD: begin
                mul_a = gain_d_reg;
                mul_b = SW'(diff_reg);
            end
            default: begin
                mul_a = gain_p_reg;
                mul_b = SW'(e_reg);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;
    assign mul_x = UW'(mul_p);

    // volts Q16.16 to 12-bit code: floor(u * 13650 / 2^16) / 11
    logic [31:0] dac_prod;
    logic [32:0] div_prod;
    assign dac_prod = 32'(u_reg[17:0]) * 32'(tpd_pkg::DAC_MUL);
    assign div_prod = 33'(w_reg) * 33'(tpd_pkg::DIV11_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= 16'sd512;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            target_reg   <= '0;
            tilt_reg     <= '0;
            last_err_reg <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tpd_pkg::REG_GAIN_P: gain_p_reg <= $signed(cfg_wdata);
                    tpd_pkg::REG_GAIN_I: gain_i_reg <= $signed(cfg_wdata);
                    tpd_pkg::REG_GAIN_D: gain_d_reg <= $signed(cfg_wdata);
                    tpd_pkg::REG_TARGET: target_reg <= $signed(cfg_wdata);
                    default: ;
                endcase
            end
            case (cmd.op)
                tpd_pkg::CMD_LOAD: begin
                    if (!s_op && s_accel_y == '0)
                        tilt_reg <= '0;
                end
                tpd_pkg::CMD_DEGDIV: tilt_reg <= zneg_reg ? -$signed(qq) : $signed(qq);
                tpd_pkg::CMD_ERR: begin
                    last_err_reg <= e_w;
                    sum_reg      <= s_sat;
                end
                default: ;
            endcase
            if (cmd.op == tpd_pkg::CMD_OUT)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            tpd_pkg::CMD_LOAD: begin
                ax_reg <= s_accel_x;
                ay_reg <= s_accel_y;
                az_reg <= s_accel_z;
            end
            tpd_pkg::CMD_SQX: sq_reg <= 32'(sqx);
            tpd_pkg::CMD_SQZ: begin
                nsh_reg  <= sq_reg + 32'(sqz);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            tpd_pkg::CMD_SQRT: begin
                nsh_reg  <= {nsh_reg[29:0], 2'b00};
                rem_reg  <= take ? 34'(rem_w - trial) : rem_w[33:0];
                root_reg <= {root_reg[30:0], take};
            end
            tpd_pkg::CMD_CINIT: begin
                cx_reg <= $signed({{(XW-32){1'b0}}, root_reg});
                cy_reg <= $signed({{(XW-32){ay_reg[15]}}, ay_reg, 16'h0000});
                cz_reg <= '0;
            end
            tpd_pkg::CMD_CSTEP: begin
                if (!cy_reg[XW-1]) begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + ang;
                end else begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - ang;
                end
            end
            tpd_pkg::CMD_DEGMUL: begin
                nrm_reg  <= deg_prod + tpd_pkg::DEG_BIAS;
                zneg_reg <= cz_reg[ZW-1];
            end
            tpd_pkg::CMD_ERR: begin
                e_reg    <= e_w;
                diff_reg <= diff_w;
            end
            tpd_pkg::CMD_MP: u_reg <= mul_x;
            tpd_pkg::CMD_MI: u_reg <= u_reg + mul_x;
            tpd_pkg::CMD_MD: u_reg <= u_reg + mul_x;
            tpd_pkg::CMD_SCALE: begin
                hi_reg <= (u_reg >= tpd_pkg::V_HIGH_MIN);
                lo_reg <= (u_reg <= tpd_pkg::V_LOW_MAX);
                w_reg  <= dac_prod[31:16];
            end
            tpd_pkg::CMD_CODE: begin
                if (hi_reg)
                    code_reg <= tpd_pkg::CODE_HIGH;
                else if (lo_reg)
                    code_reg <= tpd_pkg::CODE_LOW;
                else
                    code_reg <= div_prod[31:20];
            end
            tpd_pkg::CMD_OUT: begin
                m_dac_word_reg <= tpd_pkg::DAC_CTRL | {3'b000, code_reg};
                m_tilt_reg     <= tilt_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tilt_pid_dac_drive.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake         payload
// s_        in   s_valid/s_ready   s_op, s_accel_x, s_accel_y, s_accel_z
// m_        out  m_valid/m_ready   m_dac_word, m_tilt_now
// cfg_      in   cfg_wr_en         cfg_addr, cfg_wdata (no read-back)
//
// A sample with y = 0 sets the tilt to zero without leaving idle. Other samples pass
// through the bit-serial square root (one root bit a cycle) and the CORDIC steps.
// Tick: error, P, I, D on the shared gain multiplier, scale, code, output, any m_ready wait.
// Reset (aresetn low, synchronous) loads gain_p = 2.0, clears gains, setpoint and PID state.
// A result held in the output register stalls the next tick at its output step until m_ready.
module tilt_pid_dac_drive (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_x,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_y,
    input  wire logic signed [tpd_pkg::DATA_W-1:0]   s_accel_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [14:0]                              m_dac_word,
    output logic signed [tpd_pkg::DATA_W-1:0]        m_tilt_now,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tpd_pkg::ADDR_W-1:0]          cfg_addr,
    input  wire logic [tpd_pkg::DATA_W-1:0]          cfg_wdata
);

    tpd_pkg::cmd_t    cmd;
    tpd_pkg::status_t status;

    tpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tpd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_op       (s_op),
        .s_accel_x  (s_accel_x),
        .s_accel_y  (s_accel_y),
        .s_accel_z  (s_accel_z),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_dac_word (m_dac_word),
        .m_tilt_now (m_tilt_now)
    );

    a_ctrl_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dac_word[14:12] == 3'b111)
        else $error("dac control bits wrong");

    a_code_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dac_word[11:0] >= tpd_pkg::CODE_LOW)
        else $error("dac code below low clamp");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> !s_ready)
        else $error("input open right after tick request");

endmodule
`default_nettype wire
